// File: src/assert_macros.svh
// Assertion macros shared by the merge-by-key table RTL.
// Properties are clocked on clock and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define OMKT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// check that a condition implies an outcome in the next cycle
`define OMKT_ASSERT_NEXT(label, cond, outcome, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (outcome)) \
      else $error(msg);

`endif

// File: src/omkt_pkg.sv
// Package for the merge-by-key table: field widths, stored record and result types.
// No dependencies.
`default_nettype none

package omkt_pkg;

   localparam int NODE_KEY_W = 16;
   localparam int DEMAND_W   = 24;
   localparam int TOTAL_W    = 32;
   localparam int TIME_W     = 16;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_demand;
      logic [TIME_W-1:0]  open_t;
      logic [TIME_W-1:0]  close_t;
      logic               urgent;
   } rec_type;

   typedef struct packed {
      logic                  entry_valid;
      logic [NODE_KEY_W-1:0] out_key;
      logic [TOTAL_W-1:0]    total_demand;
      logic [TIME_W-1:0]     earliest_open;
      logic [TIME_W-1:0]     latest_close;
      logic                  any_urgent;
      logic                  overflowed;
      logic                  last;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/omkt_if.sv
// Valid/ready channel interfaces for order records and merged results.
// Depends on omkt_pkg.
`default_nettype none

interface omkt_req_if;
   import omkt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [NODE_KEY_W-1:0] node_key;
   logic [DEMAND_W-1:0]   demand;
   logic [TIME_W-1:0]     open_time;
   logic [TIME_W-1:0]     close_time;
   logic                  is_urgent;

   modport source (output valid, kind, node_key, demand, open_time, close_time, is_urgent,
                   input ready);
   modport sink (input valid, kind, node_key, demand, open_time, close_time, is_urgent,
                 output ready);
endinterface

interface omkt_rsp_if;
   import omkt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  entry_valid;
   logic [NODE_KEY_W-1:0] out_key;
   logic [TOTAL_W-1:0]    total_demand;
   logic [TIME_W-1:0]     earliest_open;
   logic [TIME_W-1:0]     latest_close;
   logic                  any_urgent;
   logic                  overflowed;
   logic                  last;

   modport source (output valid, entry_valid, out_key, total_demand, earliest_open,
                   latest_close, any_urgent, overflowed, last,
                   input ready);
   modport sink (input valid, entry_valid, out_key, total_demand, earliest_open,
                 latest_close, any_urgent, overflowed, last,
                 output ready);
endinterface

`default_nettype wire

// File: src/omkt_table.sv
// Entry memory of the merge-by-key table: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module omkt_table #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 81
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: src/omkt_merge.sv
// Shared compare and merge unit: key match, saturating demand sum, window min/max, urgent OR.
// Depends on omkt_pkg.
`default_nettype none

module omkt_merge #(
   parameter int KEY_W = 16
) (
   input  wire logic [KEY_W-1:0]       ent_key,
   input  wire omkt_pkg::rec_type      ent_rec,
   input  wire logic [KEY_W-1:0]       item_key,
   input  wire omkt_pkg::rec_type      item_rec,
   output logic                        hit,
   output omkt_pkg::rec_type           merged
);
   import omkt_pkg::*;

   logic [TOTAL_W:0] sum;

   assign hit = (ent_key == item_key);
   assign sum = {1'b0, ent_rec.total_demand} + {1'b0, item_rec.total_demand};

   always_comb begin
      merged.total_demand = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
      merged.open_t  = (item_rec.open_t < ent_rec.open_t) ? item_rec.open_t : ent_rec.open_t;
      merged.close_t = (item_rec.close_t > ent_rec.close_t) ? item_rec.close_t : ent_rec.close_t;
      merged.urgent  = ent_rec.urgent | item_rec.urgent;
   end

endmodule

`default_nettype wire

// File: src/order_merge_by_key_table.sv
// Merge-by-key table for order records: sequencer, entry memory and shared merge unit.
// Depends on omkt_pkg, omkt_if, omkt_table, omkt_merge and assert_macros.svh.
//
// Usage:
//   req_chan carries one record per transaction: kind 0 adds an order, kind 1 flushes.
//   An add scans the stored entries in insertion order, one entry per cycle through
//   the single compare/merge unit, and either merges into the first entry with the
//   same key or appends a new one. A full table drops a new key and sets a sticky
//   overflow flag. An add gives no result and occupies the block until its scan ends;
//   the scan rate is bounded by the one-entry-per-cycle memory read port.
//   A flush returns one rsp_chan transaction per entry in insertion order, last set on
//   the final one, or a single empty marker (entry_valid 0, last 1) for an empty table;
//   it then clears the table and the overflow flag. The first result passes through the
//   flush state into the result register, and one follows per cycle while rsp_chan.ready
//   stays high; a low ready holds the result register and pauses the flush.
//   req_chan.ready is high only between items. A waiting result does not block the
//   next add. Reset (synchronous, active high) empties the table and drops any
//   pending result; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module order_merge_by_key_table #(
   parameter int TABLE_DEPTH = 32,
   parameter int KEY_BITS    = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   omkt_req_if.sink   req_chan,
   omkt_rsp_if.source rsp_chan
);
   import omkt_pkg::*;

   localparam int KEY_W = (KEY_BITS < NODE_KEY_W) ? KEY_BITS : NODE_KEY_W;
   localparam int IW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int REC_W = $bits(rec_type);
   localparam int WIDTH = KEY_W + REC_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH
   } state_type;

   state_type        state_ff;
   logic [IW-1:0]    idx_ff;
   logic [CW-1:0]    count_ff;
   logic             overflow_ff;
   logic [KEY_W-1:0] item_key_ff;
   rec_type          item_rec_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             req_fire;
   logic             rsp_free;
   logic             rsp_load;
   logic             idx_last;
   logic             table_full;
   logic [IW-1:0]    idx_next;
   logic [KEY_W-1:0] req_key;
   rec_type          req_rec;
   logic [KEY_W-1:0] rd_key;
   rec_type          rd_rec;
   logic [WIDTH-1:0] rdata;
   logic             hit;
   rec_type          merged;
   logic             we;
   logic [IW-1:0]    waddr;
   logic [WIDTH-1:0] wdata;
   logic [IW-1:0]    raddr;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load   = (state_ff == S_FLUSH) && rsp_free;
   assign idx_last   = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign table_full = (count_ff == CW'(TABLE_DEPTH));
   assign idx_next   = idx_ff + IW'(1);

   assign req_key = req_chan.node_key[KEY_W-1:0];
   always_comb begin
      req_rec.total_demand = TOTAL_W'(req_chan.demand);
      req_rec.open_t       = req_chan.open_time;
      req_rec.close_t      = req_chan.close_time;
      req_rec.urgent       = req_chan.is_urgent;
   end

   assign rd_key = rdata[WIDTH-1 -: KEY_W];
   assign rd_rec = rec_type'(rdata[REC_W-1:0]);

   omkt_merge #(.KEY_W(KEY_W)) u_merge (
      .ent_key  (rd_key),
      .ent_rec  (rd_rec),
      .item_key (item_key_ff),
      .item_rec (item_rec_ff),
      .hit      (hit),
      .merged   (merged)
   );

   omkt_table #(.DEPTH(TABLE_DEPTH), .WIDTH(WIDTH)) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      we    = 1'b0;
      waddr = count_ff[IW-1:0];
      wdata = {item_key_ff, item_rec_ff};
      raddr = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            raddr = '0;
            if (req_fire && req_chan.kind == KIND_ADD && count_ff == '0) begin
               we    = 1'b1;
               waddr = '0;
               wdata = {req_key, req_rec};
            end
         end
         S_SCAN: begin
            if (hit) begin
               we    = 1'b1;
               waddr = idx_ff;
               wdata = {rd_key, merged};
            end else if (idx_last) begin
               we = !table_full;
            end else begin
               raddr = idx_next;
            end
         end
         S_FLUSH: begin
            if (rsp_free && !idx_last && count_ff != '0) begin
               raddr = idx_next;
            end
         end
         default: begin
            raddr = idx_ff;
         end
      endcase
   end

   always_comb begin
      rsp_in            = '0;
      rsp_in.overflowed = overflow_ff;
      rsp_in.last       = 1'b1;
      if (count_ff != '0) begin
         rsp_in.entry_valid   = 1'b1;
         rsp_in.out_key       = NODE_KEY_W'(rd_key);
         rsp_in.total_demand  = rd_rec.total_demand;
         rsp_in.earliest_open = rd_rec.open_t;
         rsp_in.latest_close  = rd_rec.close_t;
         rsp_in.any_urgent    = rd_rec.urgent;
         rsp_in.last          = idx_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_chan.ready);
         unique case (state_ff)
            S_IDLE: begin
               idx_ff <= '0;
               if (req_fire) begin
                  item_key_ff <= req_key;
                  item_rec_ff <= req_rec;
                  if (req_chan.kind == KIND_FLUSH) begin
                     state_ff <= S_FLUSH;
                  end else if (count_ff == '0) begin
                     count_ff <= CW'(1);
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (hit) begin
                  state_ff <= S_IDLE;
               end else if (idx_last) begin
                  state_ff <= S_IDLE;
                  if (table_full) begin
                     overflow_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CW'(1);
                  end
               end else begin
                  idx_ff <= idx_next;
               end
            end
            S_FLUSH: begin
               if (rsp_free) begin
                  rsp_ff <= rsp_in;
                  if (count_ff == '0 || idx_last) begin
                     state_ff    <= S_IDLE;
                     count_ff    <= '0;
                     overflow_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_next;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.entry_valid   = rsp_ff.entry_valid;
   assign rsp_chan.out_key       = rsp_ff.out_key;
   assign rsp_chan.total_demand  = rsp_ff.total_demand;
   assign rsp_chan.earliest_open = rsp_ff.earliest_open;
   assign rsp_chan.latest_close  = rsp_ff.latest_close;
   assign rsp_chan.any_urgent    = rsp_ff.any_urgent;
   assign rsp_chan.overflowed    = rsp_ff.overflowed;
   assign rsp_chan.last          = rsp_ff.last;

   `OMKT_ASSERT(a_count_bound, count_ff <= CW'(TABLE_DEPTH), "entry count beyond table depth")
   `OMKT_ASSERT(a_empty_is_last, !rsp_valid_ff || rsp_ff.entry_valid || rsp_ff.last,
                "empty marker without last")
   `OMKT_ASSERT(a_write_state, !we || state_ff == S_IDLE || state_ff == S_SCAN,
                "table write outside add")
   `OMKT_ASSERT_NEXT(a_flush_clears, state_ff == S_FLUSH && state_ff != $past(state_ff),
                     $past(count_ff) == count_ff || count_ff == '0, "count moved at flush start")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for order_merge_by_key_table: random and directed order records, flush checks.
// Depends on omkt_pkg, omkt_if and the order_merge_by_key_table RTL.
// A shadow table predicts every flush result; results are compared field by field.
module tb;
   import omkt_pkg::*;

   localparam int TBL_DEPTH  = 32;
   localparam int DRAIN_CYC  = 40;
   localparam int HOLD_CYC   = 400;

   typedef struct packed {
      logic                  kind;
      logic [NODE_KEY_W-1:0] key;
      logic [DEMAND_W-1:0]   demand;
      logic [TIME_W-1:0]     open_t;
      logic [TIME_W-1:0]     close_t;
      logic                  urgent;
   } order_type;

   typedef enum int {SEQ_POOL, SEQ_FILL, SEQ_NOISE, SEQ_SHORT} seq_kind_type;
   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} rdy_mode_type;

   logic clock = 1'b0;
   logic reset;

   omkt_req_if req_chan ();
   omkt_rsp_if rsp_chan ();

   order_merge_by_key_table #(
      .TABLE_DEPTH (TBL_DEPTH),
      .KEY_BITS    (NODE_KEY_W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   order_type             orders_pending[$];
   rsp_type               flush_rows_due[$];
   logic [NODE_KEY_W-1:0] tbl_key[TBL_DEPTH];
   logic [TOTAL_W-1:0]    tbl_demand[TBL_DEPTH];
   logic [TIME_W-1:0]     tbl_open[TBL_DEPTH];
   logic [TIME_W-1:0]     tbl_close[TBL_DEPTH];
   logic                  tbl_urgent[TBL_DEPTH];
   int                    tbl_count = 0;
   logic                  tbl_ovf = 1'b0;

   int           errors = 0;
   int           flushes_taken = 0;
   int           rows_seen = 0;
   bit           order_taken = 1'b0;
   int           burst_left = 0;
   int           gap_left = 0;
   bit           hold_rsp = 1'b0;
   rdy_mode_type rdy_mode = RDY_ALWAYS;
   int           rdy_left = 0;
   bit           rdy_next;
   order_type    cur_order;
   order_type    taken_order;
   rsp_type      want_row;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("result %0d: %s got %0h want %0h", rows_seen, what, got, want);
      errors++;
   endtask

   task automatic merge_order(input order_type o);
      int      i;
      bit      hit;
      rsp_type row;
      logic [TOTAL_W:0] sum;
      if (o.kind == KIND_ADD) begin
         hit = 1'b0;
         for (i = 0; i < tbl_count && !hit; i++) begin
            if (tbl_key[i] == o.key) begin
               sum = {1'b0, tbl_demand[i]} + o.demand;
               tbl_demand[i] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
               if (o.open_t < tbl_open[i]) tbl_open[i] = o.open_t;
               if (o.close_t > tbl_close[i]) tbl_close[i] = o.close_t;
               tbl_urgent[i] = tbl_urgent[i] | o.urgent;
               hit = 1'b1;
            end
         end
         if (!hit) begin
            if (tbl_count >= TBL_DEPTH) begin
               tbl_ovf = 1'b1;
            end else begin
               tbl_key[tbl_count]    = o.key;
               tbl_demand[tbl_count] = o.demand;
               tbl_open[tbl_count]   = o.open_t;
               tbl_close[tbl_count]  = o.close_t;
               tbl_urgent[tbl_count] = o.urgent;
               tbl_count++;
            end
         end
      end else begin
         if (tbl_count == 0) begin
            row            = '0;
            row.overflowed = tbl_ovf;
            row.last       = 1'b1;
            flush_rows_due.insert(flush_rows_due.size(), row);
         end
         for (i = 0; i < tbl_count; i++) begin
            row.entry_valid   = 1'b1;
            row.out_key       = tbl_key[i];
            row.total_demand  = tbl_demand[i];
            row.earliest_open = tbl_open[i];
            row.latest_close  = tbl_close[i];
            row.any_urgent    = tbl_urgent[i];
            row.overflowed    = tbl_ovf;
            row.last          = (i == tbl_count - 1);
            flush_rows_due.insert(flush_rows_due.size(), row);
         end
         tbl_count = 0;
         tbl_ovf   = 1'b0;
      end
   endtask

   task automatic add_order(input logic [NODE_KEY_W-1:0] key, input logic [DEMAND_W-1:0] dem,
                            input logic [TIME_W-1:0] op, input logic [TIME_W-1:0] cl,
                            input logic urg);
      order_type o;
      o = '{KIND_ADD, key, dem, op, cl, urg};
      orders_pending.insert(orders_pending.size(), o);
   endtask

   task automatic flush_table();
      order_type o;
      o = '{KIND_FLUSH, 16'($urandom), 24'($urandom), 16'($urandom),
            16'($urandom), 1'($urandom)};
      orders_pending.insert(orders_pending.size(), o);
   endtask

   function automatic logic [DEMAND_W-1:0] pick_demand();
      case ($urandom_range(0, 7))
         0: pick_demand = '0;
         1: pick_demand = '1;
         2: pick_demand = DEMAND_W'($urandom_range(0, 255));
         default: pick_demand = DEMAND_W'($urandom);
      endcase
   endfunction

   task automatic add_random(input logic [NODE_KEY_W-1:0] key);
      add_order(key, pick_demand(), 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic build_directed();
      int i;
      flush_table();
      add_order(16'h0000, 24'hFFFFFF, 16'hFFFF, 16'h0000, 1'b0);
      add_order(16'hFFFF, 24'h000000, 16'h0000, 16'hFFFF, 1'b1);
      add_order(16'h0000, 24'hFFFFFF, 16'h0000, 16'hFFFF, 1'b1);
      add_order(16'hFFFF, 24'h000001, 16'h8000, 16'h7FFF, 1'b0);
      add_order(16'h5A5A, 24'h800000, 16'h1234, 16'h1233, 1'b0);
      add_order(16'h5A5A, 24'h7FFFFF, 16'h1235, 16'h1232, 1'b0);
      add_order(16'hA5A5, 24'h555555, 16'hAAAA, 16'h5555, 1'b1);
      flush_table();
      flush_table();
      for (i = 0; i < 12; i++) add_order(16'h1357, 24'hFFFFFF, 16'(i), 16'(i), 1'b0);
      add_order(16'h1357, 24'h000010, 16'h0001, 16'h0002, 1'b1);
      flush_table();
      for (i = 0; i < TBL_DEPTH; i++) add_random(16'(i * 16'h0803) ^ 16'h00F0);
      add_random(16'hFFFE);
      add_random(16'(7 * 16'h0803) ^ 16'h00F0);
      flush_table();
      flush_table();
   endtask

   task automatic build_random(input int target);
      int                    made;
      int                    n;
      int                    i;
      seq_kind_type          seq;
      logic [NODE_KEY_W-1:0] pool[4];
      logic [NODE_KEY_W-1:0] prev_key;
      made = 0;
      prev_key = '0;
      while (made < target) begin
         seq = seq_kind_type'($urandom_range(0, 3));
         case (seq)
            SEQ_POOL: begin
               for (i = 0; i < 4; i++) pool[i] = 16'($urandom);
               n = $urandom_range(2, 12);
               for (i = 0; i < n; i++) add_random(pool[$urandom_range(0, 3)]);
               flush_table();
               made += n + 1;
            end
            SEQ_FILL: begin
               n = $urandom_range(30, 40);
               for (i = 0; i < n; i++) begin
                  if ($urandom_range(0, 7) != 0) prev_key = 16'($urandom);
                  add_random(prev_key);
               end
               flush_table();
               made += n + 1;
            end
            SEQ_NOISE: begin
               n = $urandom_range(3, 15);
               for (i = 0; i < n; i++) begin
                  if ($urandom_range(0, 4) == 0) flush_table();
                  else add_random(16'($urandom_range(0, 3)) << $urandom_range(0, 14));
               end
               made += n;
            end
            default: begin
               n = $urandom_range(0, 2);
               for (i = 0; i < n; i++) add_random(16'($urandom));
               flush_table();
               made += n + 1;
            end
         endcase
      end
      flush_table();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || order_taken) begin
         order_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (orders_pending.size() > 0) begin
            cur_order = orders_pending.pop_front();
            req_chan.kind       <= cur_order.kind;
            req_chan.node_key   <= cur_order.key;
            req_chan.demand     <= cur_order.demand;
            req_chan.open_time  <= cur_order.open_t;
            req_chan.close_time <= cur_order.close_t;
            req_chan.is_urgent  <= cur_order.urgent;
            req_chan.valid      <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         order_taken = 1'b1;
         taken_order = '{req_chan.kind, req_chan.node_key, req_chan.demand,
                         req_chan.open_time, req_chan.close_time, req_chan.is_urgent};
         merge_order(taken_order);
         if (taken_order.kind == KIND_FLUSH) flushes_taken++;
      end
   end

   always @(negedge clock) begin
      if (rdy_left == 0) begin
         rdy_mode = rdy_mode_type'($urandom_range(0, 3));
         rdy_left = $urandom_range(8, 80);
      end else begin
         rdy_left--;
      end
      case (rdy_mode)
         RDY_ALWAYS: rdy_next = 1'b1;
         RDY_COIN:   rdy_next = 1'($urandom);
         RDY_SPARSE: rdy_next = ($urandom_range(0, 3) == 0);
         default:    rdy_next = ~rsp_chan.ready;
      endcase
      rsp_chan.ready <= rdy_next && !hold_rsp;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rows_seen++;
         if (flush_rows_due.size() == 0) begin
            report_mismatch("unexpected transaction, key", rsp_chan.out_key, '0);
         end else begin
            want_row = flush_rows_due.pop_front();
            if (rsp_chan.entry_valid !== want_row.entry_valid)
               report_mismatch("entry_valid", rsp_chan.entry_valid, want_row.entry_valid);
            if (rsp_chan.out_key !== want_row.out_key)
               report_mismatch("out_key", rsp_chan.out_key, want_row.out_key);
            if (rsp_chan.total_demand !== want_row.total_demand)
               report_mismatch("total_demand", rsp_chan.total_demand, want_row.total_demand);
            if (rsp_chan.earliest_open !== want_row.earliest_open)
               report_mismatch("earliest_open", rsp_chan.earliest_open,
                               want_row.earliest_open);
            if (rsp_chan.latest_close !== want_row.latest_close)
               report_mismatch("latest_close", rsp_chan.latest_close, want_row.latest_close);
            if (rsp_chan.any_urgent !== want_row.any_urgent)
               report_mismatch("any_urgent", rsp_chan.any_urgent, want_row.any_urgent);
            if (rsp_chan.overflowed !== want_row.overflowed)
               report_mismatch("overflowed", rsp_chan.overflowed, want_row.overflowed);
            if (rsp_chan.last !== want_row.last)
               report_mismatch("last", rsp_chan.last, want_row.last);
         end
      end
   end

   // hold off the result channel during a full-table flush
   initial begin
      wait (flushes_taken >= 5);
      hold_rsp = 1'b1;
      repeat (HOLD_CYC) @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[order_merge_by_key_table] ERROR");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.kind       = KIND_ADD;
      req_chan.node_key   = '0;
      req_chan.demand     = '0;
      req_chan.open_time  = '0;
      req_chan.close_time = '0;
      req_chan.is_urgent  = 1'b0;
      rsp_chan.ready      = 1'b0;
      build_directed();
      build_random(160);
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      while (orders_pending.size() != 0 || req_chan.valid) @(posedge clock);
      while (flush_rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (errors == 0)
         $display("[order_merge_by_key_table] OK");
      else
         $display("[order_merge_by_key_table] ERROR");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/omkt_pkg.sv
src/omkt_if.sv
src/omkt_table.sv
src/omkt_merge.sv
src/order_merge_by_key_table.sv
tb/sv/tb.sv
